/* rtl/lfls_pkg.sv */
// ----------------------------------------------------------------------------
// lfls_pkg
// Shared constants and register codes for the line-follow lap steering unit.
// ----------------------------------------------------------------------------
package lfls_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int LAP_BITS_DEF    = 4;

  localparam int CRUISE_W  = 8;
  localparam int DUTY_W    = 8;
  localparam int SPEED_W   = 10;
  localparam int CFG_IDX_W = 3;

  localparam int CW_OFFSET   = 22;
  localparam int CW_DEC      = 1;
  localparam int ACW_OFFSET  = 6;
  localparam int ACW_DEC     = 6;
  localparam int SPEED_RESET = 100;
  localparam int DUTY_TOP    = 255;

  localparam int CRUISE_RST    = 85;
  localparam int CLOCKWISE_RST = 1;
  localparam int REF_RST       = 0;
  localparam int LAP_LIMIT_RST = 2;
  localparam int OBSTACLE_RST  = 30;
  localparam int BLACK_RST     = 900;
  localparam int WHITE_RST     = 700;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CRUISE    = 3'd0,
    REG_CLOCKWISE = 3'd1,
    REG_LEFT_REF  = 3'd2,
    REG_RIGHT_REF = 3'd3,
    REG_LAP_LIMIT = 3'd4,
    REG_OBSTACLE  = 3'd5,
    REG_BLACK     = 3'd6,
    REG_WHITE     = 3'd7
  } cfg_reg_e;

endpackage

/* rtl/lfls_cfg.sv */
// ----------------------------------------------------------------------------
// lfls_cfg
// Configuration register file, one write beat per cycle.
// ----------------------------------------------------------------------------
module lfls_cfg #(
  parameter int SAMPLE_BITS = lfls_pkg::SAMPLE_BITS_DEF,
  parameter int LAP_BITS    = lfls_pkg::LAP_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               we_i,
  input  logic [lfls_pkg::CFG_IDX_W-1:0]     idx_i,
  input  logic [SAMPLE_BITS-1:0]             wdata_i,
  output logic [lfls_pkg::CRUISE_W-1:0]      cruise_o,
  output logic                               clockwise_o,
  output logic [SAMPLE_BITS-1:0]             left_ref_o,
  output logic [SAMPLE_BITS-1:0]             right_ref_o,
  output logic [LAP_BITS-1:0]                lap_limit_o,
  output logic [SAMPLE_BITS-1:0]             obstacle_o,
  output logic [SAMPLE_BITS-1:0]             black_o,
  output logic [SAMPLE_BITS-1:0]             white_o
);

  logic [lfls_pkg::CRUISE_W-1:0] cruise_q;
  logic                          clockwise_q;
  logic [SAMPLE_BITS-1:0]        left_ref_q;
  logic [SAMPLE_BITS-1:0]        right_ref_q;
  logic [LAP_BITS-1:0]           lap_limit_q;
  logic [SAMPLE_BITS-1:0]        obstacle_q;
  logic [SAMPLE_BITS-1:0]        black_q;
  logic [SAMPLE_BITS-1:0]        white_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cruise_q    <= lfls_pkg::CRUISE_W'(lfls_pkg::CRUISE_RST);
      clockwise_q <= 1'(lfls_pkg::CLOCKWISE_RST);
      left_ref_q  <= SAMPLE_BITS'(lfls_pkg::REF_RST);
      right_ref_q <= SAMPLE_BITS'(lfls_pkg::REF_RST);
      lap_limit_q <= LAP_BITS'(lfls_pkg::LAP_LIMIT_RST);
      obstacle_q  <= SAMPLE_BITS'(lfls_pkg::OBSTACLE_RST);
      black_q     <= SAMPLE_BITS'(lfls_pkg::BLACK_RST);
      white_q     <= SAMPLE_BITS'(lfls_pkg::WHITE_RST);
    end else if (we_i) begin
      unique case (lfls_pkg::cfg_reg_e'(idx_i))
        lfls_pkg::REG_CRUISE:    cruise_q    <= wdata_i[lfls_pkg::CRUISE_W-1:0];
        lfls_pkg::REG_CLOCKWISE: clockwise_q <= wdata_i[0];
        lfls_pkg::REG_LEFT_REF:  left_ref_q  <= wdata_i;
        lfls_pkg::REG_RIGHT_REF: right_ref_q <= wdata_i;
        lfls_pkg::REG_LAP_LIMIT: lap_limit_q <= wdata_i[LAP_BITS-1:0];
        lfls_pkg::REG_OBSTACLE:  obstacle_q  <= wdata_i;
        lfls_pkg::REG_BLACK:     black_q     <= wdata_i;
        lfls_pkg::REG_WHITE:     white_q     <= wdata_i;
        default: ;
      endcase
    end
  end

  assign cruise_o    = cruise_q;
  assign clockwise_o = clockwise_q;
  assign left_ref_o  = left_ref_q;
  assign right_ref_o = right_ref_q;
  assign lap_limit_o = lap_limit_q;
  assign obstacle_o  = obstacle_q;
  assign black_o     = black_q;
  assign white_o     = white_q;

endmodule

/* rtl/lfls_core.sv */
// ----------------------------------------------------------------------------
// lfls_core
// Steering and lap state with the per-beat update and result encoding.
// ----------------------------------------------------------------------------
module lfls_core #(
  parameter int SAMPLE_BITS = lfls_pkg::SAMPLE_BITS_DEF,
  parameter int LAP_BITS    = lfls_pkg::LAP_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [SAMPLE_BITS-1:0]        left_sample_i,
  input  logic [SAMPLE_BITS-1:0]        right_sample_i,
  input  logic [SAMPLE_BITS-1:0]        obstacle_distance_i,
  input  logic [lfls_pkg::CRUISE_W-1:0] cruise_i,
  input  logic                          clockwise_i,
  input  logic [SAMPLE_BITS-1:0]        left_ref_i,
  input  logic [SAMPLE_BITS-1:0]        right_ref_i,
  input  logic [LAP_BITS-1:0]           lap_limit_i,
  input  logic [SAMPLE_BITS-1:0]        obstacle_i,
  input  logic [SAMPLE_BITS-1:0]        black_i,
  input  logic [SAMPLE_BITS-1:0]        white_i,
  output logic                          left_forward_o,
  output logic                          right_forward_o,
  output logic [lfls_pkg::DUTY_W-1:0]   left_duty_o,
  output logic [lfls_pkg::DUTY_W-1:0]   right_duty_o,
  output logic [LAP_BITS-1:0]           laps_done_o,
  output logic                          stopped_for_good_o,
  output logic                          halted_o,
  output logic [LAP_BITS-1:0]           lap_count_o
);

  localparam int SW1 = SAMPLE_BITS + 1;
  localparam int SPW = lfls_pkg::SPEED_W;

  typedef logic signed [SPW-1:0] speed_t;

  speed_t              left_speed_q, left_speed_d;
  speed_t              right_speed_q, right_speed_d;
  logic [LAP_BITS-1:0] lap_q, lap_d;
  logic                lb_q, lb_d, rb_q, rb_d, lw_q, lw_d, rw_q, rw_d;
  logic                halted_q, halted_d;

  logic [SW1-1:0] lv, rv, lref, rref;
  logic           stop;
  speed_t         cruise;
  speed_t         l_out, r_out;
  speed_t         l_mag, r_mag;

  function automatic speed_t lower(speed_t s, speed_t dec);
    return (s > 0) ? speed_t'(s - dec) : '0;
  endfunction

  always_comb begin
    lv     = SW1'(left_sample_i);
    rv     = SW1'(right_sample_i);
    lref   = SW1'(left_ref_i);
    rref   = SW1'(right_ref_i);
    cruise = speed_t'({2'b00, cruise_i});

    left_speed_d  = left_speed_q;
    right_speed_d = right_speed_q;
    lap_d         = lap_q;
    lb_d          = lb_q;
    rb_d          = rb_q;
    lw_d          = lw_q;
    rw_d          = rw_q;
    halted_d      = halted_q;
    stop          = 1'b1;

    if (halted_q || obstacle_distance_i <= obstacle_i) begin
      stop = 1'b1;
    end else if (lap_q >= lap_limit_i) begin
      halted_d = 1'b1;
    end else begin
      stop = 1'b0;
      lb_d = lb_q | (left_sample_i > black_i);
      rb_d = rb_q | (right_sample_i > black_i);
      if (lb_d && rb_d) begin
        lw_d = lw_q | (left_sample_i < white_i);
        rw_d = rw_q | (right_sample_i < white_i);
        if (lw_d && rw_d) begin
          lap_d = lap_q + 1'b1;
          lb_d  = 1'b0;
          rb_d  = 1'b0;
          lw_d  = 1'b0;
          rw_d  = 1'b0;
        end
      end
      left_speed_d  = cruise;
      right_speed_d = cruise;
      if (clockwise_i) begin
        if (lv + SW1'(lfls_pkg::CW_OFFSET) <= lref) begin
          left_speed_d = lower(left_speed_q, speed_t'(lfls_pkg::CW_DEC));
        end else if (rv >= rref + SW1'(lfls_pkg::CW_OFFSET)) begin
          right_speed_d = lower(right_speed_q, speed_t'(lfls_pkg::CW_DEC));
        end
      end else begin
        if (rv + SW1'(lfls_pkg::ACW_OFFSET) <= rref) begin
          right_speed_d = lower(right_speed_q, speed_t'(lfls_pkg::ACW_DEC));
        end else if (lv >= lref + SW1'(lfls_pkg::ACW_OFFSET)) begin
          left_speed_d = lower(left_speed_q, speed_t'(lfls_pkg::ACW_DEC));
        end
      end
    end

    l_out = stop ? '0 : left_speed_d;
    r_out = stop ? '0 : right_speed_d;
    l_mag = (l_out < 0) ? speed_t'(-l_out) : l_out;
    r_mag = (r_out < 0) ? speed_t'(-r_out) : r_out;

    left_forward_o     = (l_out >= 0);
    right_forward_o    = (r_out >= 0);
    left_duty_o        = lfls_pkg::DUTY_W'(lfls_pkg::DUTY_TOP) - l_mag[lfls_pkg::DUTY_W-1:0];
    right_duty_o       = lfls_pkg::DUTY_W'(lfls_pkg::DUTY_TOP) - r_mag[lfls_pkg::DUTY_W-1:0];
    laps_done_o        = lap_d;
    stopped_for_good_o = halted_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_speed_q  <= speed_t'(lfls_pkg::SPEED_RESET);
      right_speed_q <= speed_t'(lfls_pkg::SPEED_RESET);
      lap_q         <= '0;
      lb_q          <= 1'b0;
      rb_q          <= 1'b0;
      lw_q          <= 1'b0;
      rw_q          <= 1'b0;
      halted_q      <= 1'b0;
    end else if (step_i) begin
      left_speed_q  <= left_speed_d;
      right_speed_q <= right_speed_d;
      lap_q         <= lap_d;
      lb_q          <= lb_d;
      rb_q          <= rb_d;
      lw_q          <= lw_d;
      rw_q          <= rw_d;
      halted_q      <= halted_d;
    end
  end

  assign halted_o    = halted_q;
  assign lap_count_o = lap_q;

endmodule

/* rtl/line_follow_lap_steering_unit.sv */
// ----------------------------------------------------------------------------
// line_follow_lap_steering_unit
// Line-follow steering with lap counting and obstacle stop.
// ----------------------------------------------------------------------------
// Accepts one sample beat per cycle and returns one result beat per sample.
// The sample lands in an input register, the steering and lap update run in
// a single combinational pass, and the result is held in an output register.
// Throughput is one beat per cycle, limited only by out_ready_i.
// Configuration writes are taken at once (cfg_ready_o is always high) and
// should be made while no beat is in flight.
module line_follow_lap_steering_unit #(
  parameter int SAMPLE_BITS = lfls_pkg::SAMPLE_BITS_DEF,
  parameter int LAP_BITS    = lfls_pkg::LAP_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [SAMPLE_BITS-1:0]         left_sample_i,
  input  logic [SAMPLE_BITS-1:0]         right_sample_i,
  input  logic [SAMPLE_BITS-1:0]         obstacle_distance_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           left_forward_o,
  output logic                           right_forward_o,
  output logic [lfls_pkg::DUTY_W-1:0]    left_duty_o,
  output logic [lfls_pkg::DUTY_W-1:0]    right_duty_o,
  output logic [LAP_BITS-1:0]            laps_done_o,
  output logic                           stopped_for_good_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lfls_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SAMPLE_BITS-1:0]         cfg_wdata_i
);

  logic [lfls_pkg::CRUISE_W-1:0] cruise;
  logic                          clockwise;
  logic [SAMPLE_BITS-1:0]        left_ref, right_ref, obstacle, black, white;
  logic [LAP_BITS-1:0]           lap_limit;

  logic                   s1_valid_q;
  logic [SAMPLE_BITS-1:0] s1_left_q, s1_right_q, s1_dist_q;
  logic                   advance, step;

  logic                        lf_d, rf_d, stop_d;
  logic [lfls_pkg::DUTY_W-1:0] ld_d, rd_d;
  logic [LAP_BITS-1:0]         laps_d;
  logic                        halted;
  logic [LAP_BITS-1:0]         lap_count;

  logic                        out_valid_q;
  logic                        lf_q, rf_q, stop_q;
  logic [lfls_pkg::DUTY_W-1:0] ld_q, rd_q;
  logic [LAP_BITS-1:0]         laps_q;

  assign cfg_ready_o = 1'b1;

  lfls_cfg #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .LAP_BITS   (LAP_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (cfg_valid_i),
    .idx_i      (cfg_index_i),
    .wdata_i    (cfg_wdata_i),
    .cruise_o   (cruise),
    .clockwise_o(clockwise),
    .left_ref_o (left_ref),
    .right_ref_o(right_ref),
    .lap_limit_o(lap_limit),
    .obstacle_o (obstacle),
    .black_o    (black),
    .white_o    (white)
  );

  assign advance    = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_left_q  <= left_sample_i;
      s1_right_q <= right_sample_i;
      s1_dist_q  <= obstacle_distance_i;
    end
  end

  lfls_core #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .LAP_BITS   (LAP_BITS)
  ) u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (step),
    .left_sample_i      (s1_left_q),
    .right_sample_i     (s1_right_q),
    .obstacle_distance_i(s1_dist_q),
    .cruise_i           (cruise),
    .clockwise_i        (clockwise),
    .left_ref_i         (left_ref),
    .right_ref_i        (right_ref),
    .lap_limit_i        (lap_limit),
    .obstacle_i         (obstacle),
    .black_i            (black),
    .white_i            (white),
    .left_forward_o     (lf_d),
    .right_forward_o    (rf_d),
    .left_duty_o        (ld_d),
    .right_duty_o       (rd_d),
    .laps_done_o        (laps_d),
    .stopped_for_good_o (stop_d),
    .halted_o           (halted),
    .lap_count_o        (lap_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      lf_q   <= lf_d;
      rf_q   <= rf_d;
      ld_q   <= ld_d;
      rd_q   <= rd_d;
      laps_q <= laps_d;
      stop_q <= stop_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign left_forward_o     = lf_q;
  assign right_forward_o    = rf_q;
  assign left_duty_o        = ld_q;
  assign right_duty_o       = rd_q;
  assign laps_done_o        = laps_q;
  assign stopped_for_good_o = stop_q;

  // halted result beat always carries the stop drive
  a_halt_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stopped_for_good_o |->
      left_forward_o && right_forward_o &&
      left_duty_o == lfls_pkg::DUTY_W'(lfls_pkg::DUTY_TOP) &&
      right_duty_o == lfls_pkg::DUTY_W'(lfls_pkg::DUTY_TOP))
    else $error("halted beat without stop drive");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted |=> halted)
    else $error("halt cleared without reset");

  a_lap_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> lap_count == $past(lap_count))
    else $error("lap count moved without a beat");

  a_result_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> laps_done_o == lap_count && stopped_for_good_o == halted)
    else $error("result beat out of step with state");

endmodule

/* test/lfls_steering_checker.sv */
// ----------------------------------------------------------------------------
// lfls_steering_checker
// Scoreboard for the line-follow lap steering unit.
// ----------------------------------------------------------------------------
// Watches the register, sample and result channels. Each accepted sample beat
// runs through a local model of the obstacle stop, lap counter, halt and
// steering logic. The expected result is queued and checked field by field
// against the next accepted result beat.
// ----------------------------------------------------------------------------
module lfls_steering_checker #(
  parameter int SAMPLE_BITS = lfls_pkg::SAMPLE_BITS_DEF,
  parameter int LAP_BITS    = lfls_pkg::LAP_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [SAMPLE_BITS-1:0]         left_sample_i,
  input  logic [SAMPLE_BITS-1:0]         right_sample_i,
  input  logic [SAMPLE_BITS-1:0]         obstacle_distance_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic                           left_forward_i,
  input  logic                           right_forward_i,
  input  logic [lfls_pkg::DUTY_W-1:0]    left_duty_i,
  input  logic [lfls_pkg::DUTY_W-1:0]    right_duty_i,
  input  logic [LAP_BITS-1:0]            laps_done_i,
  input  logic                           stopped_for_good_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [lfls_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SAMPLE_BITS-1:0]         cfg_wdata_i,
  output int                             pending_o,
  output int                             errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SPW = lfls_pkg::SPEED_W;
  localparam int DW  = lfls_pkg::DUTY_W;

  typedef struct packed {
    logic          left_fwd;
    logic          right_fwd;
    logic [DW-1:0] left_duty;
    logic [DW-1:0] right_duty;
    logic [LAP_BITS-1:0] laps;
    logic          halted;
  } motor_cmd_t;

  logic [lfls_pkg::CRUISE_W-1:0] cruise_q;
  logic                          clockwise_q;
  logic [SAMPLE_BITS-1:0]        left_ref_q;
  logic [SAMPLE_BITS-1:0]        right_ref_q;
  logic [SAMPLE_BITS-1:0]        obstacle_q;
  logic [SAMPLE_BITS-1:0]        black_q;
  logic [SAMPLE_BITS-1:0]        white_q;
  logic [LAP_BITS-1:0]           lap_limit_q;

  logic signed [SPW-1:0] left_speed_q;
  logic signed [SPW-1:0] right_speed_q;
  logic [LAP_BITS-1:0]   lap_count_q;
  logic                  left_black_q;
  logic                  right_black_q;
  logic                  left_white_q;
  logic                  right_white_q;
  logic                  halted_q;

  motor_cmd_t motor_expected_q[$];
  int         mismatch_count = 0;
  int         pending_count  = 0;

  assign errors_o  = mismatch_count;
  assign pending_o = pending_count;

  function automatic int slow_down(input int speed, input int dec);
    return (speed > 0) ? speed - dec : 0;
  endfunction

  function automatic motor_cmd_t motor_cmd(input logic stop);
    int l;
    int r;
    int lm;
    int rm;
    motor_cmd_t cmd;
    l  = stop ? 0 : int'(left_speed_q);
    r  = stop ? 0 : int'(right_speed_q);
    lm = (l < 0) ? -l : l;
    rm = (r < 0) ? -r : r;
    cmd.left_fwd   = (l >= 0);
    cmd.right_fwd  = (r >= 0);
    cmd.left_duty  = DW'(lfls_pkg::DUTY_TOP - lm);
    cmd.right_duty = DW'(lfls_pkg::DUTY_TOP - rm);
    cmd.laps       = lap_count_q;
    cmd.halted     = halted_q;
    return cmd;
  endfunction

  task automatic reset_track();
    cruise_q      = lfls_pkg::CRUISE_W'(lfls_pkg::CRUISE_RST);
    clockwise_q   = 1'(lfls_pkg::CLOCKWISE_RST);
    left_ref_q    = SAMPLE_BITS'(lfls_pkg::REF_RST);
    right_ref_q   = SAMPLE_BITS'(lfls_pkg::REF_RST);
    lap_limit_q   = LAP_BITS'(lfls_pkg::LAP_LIMIT_RST);
    obstacle_q    = SAMPLE_BITS'(lfls_pkg::OBSTACLE_RST);
    black_q       = SAMPLE_BITS'(lfls_pkg::BLACK_RST);
    white_q       = SAMPLE_BITS'(lfls_pkg::WHITE_RST);
    left_speed_q  = SPW'(lfls_pkg::SPEED_RESET);
    right_speed_q = SPW'(lfls_pkg::SPEED_RESET);
    lap_count_q   = '0;
    left_black_q  = 1'b0;
    right_black_q = 1'b0;
    left_white_q  = 1'b0;
    right_white_q = 1'b0;
    halted_q      = 1'b0;
  endtask

  task automatic write_register(input logic [lfls_pkg::CFG_IDX_W-1:0] idx,
                                input logic [SAMPLE_BITS-1:0] data);
    case (lfls_pkg::cfg_reg_e'(idx))
      lfls_pkg::REG_CRUISE:    cruise_q    = data[lfls_pkg::CRUISE_W-1:0];
      lfls_pkg::REG_CLOCKWISE: clockwise_q = data[0];
      lfls_pkg::REG_LEFT_REF:  left_ref_q  = data;
      lfls_pkg::REG_RIGHT_REF: right_ref_q = data;
      lfls_pkg::REG_LAP_LIMIT: lap_limit_q = data[LAP_BITS-1:0];
      lfls_pkg::REG_OBSTACLE:  obstacle_q  = data;
      lfls_pkg::REG_BLACK:     black_q     = data;
      lfls_pkg::REG_WHITE:     white_q     = data;
      default: ;
    endcase
  endtask

  task automatic steer_predict(input logic [SAMPLE_BITS-1:0] ls,
                               input logic [SAMPLE_BITS-1:0] rs,
                               input logic [SAMPLE_BITS-1:0] distance);
    int lv;
    int rv;
    int lref;
    int rref;
    int cruise;
    int lsp;
    int rsp;
    lv     = int'(ls);
    rv     = int'(rs);
    lref   = int'(left_ref_q);
    rref   = int'(right_ref_q);
    cruise = int'(cruise_q);
    lsp    = int'(left_speed_q);
    rsp    = int'(right_speed_q);

    if (halted_q || distance <= obstacle_q) begin
      motor_expected_q.push_back(motor_cmd(1'b1));
      return;
    end
    if (lap_count_q >= lap_limit_q) begin
      halted_q = 1'b1;
      motor_expected_q.push_back(motor_cmd(1'b1));
      return;
    end

    if (lv > int'(black_q)) left_black_q = 1'b1;
    if (rv > int'(black_q)) right_black_q = 1'b1;
    if (left_black_q && right_black_q) begin
      if (lv < int'(white_q)) left_white_q = 1'b1;
      if (rv < int'(white_q)) right_white_q = 1'b1;
      if (left_white_q && right_white_q) begin
        lap_count_q   = lap_count_q + 1'b1;
        left_black_q  = 1'b0;
        right_black_q = 1'b0;
        left_white_q  = 1'b0;
        right_white_q = 1'b0;
      end
    end

    if (clockwise_q) begin
      if (lv <= lref - lfls_pkg::CW_OFFSET) begin
        lsp = slow_down(lsp, lfls_pkg::CW_DEC);
        rsp = cruise;
      end else if (rv >= rref + lfls_pkg::CW_OFFSET) begin
        rsp = slow_down(rsp, lfls_pkg::CW_DEC);
        lsp = cruise;
      end else begin
        lsp = cruise;
        rsp = cruise;
      end
    end else begin
      if (rv <= rref - lfls_pkg::ACW_OFFSET) begin
        rsp = slow_down(rsp, lfls_pkg::ACW_DEC);
        lsp = cruise;
      end else if (lv >= lref + lfls_pkg::ACW_OFFSET) begin
        lsp = slow_down(lsp, lfls_pkg::ACW_DEC);
        rsp = cruise;
      end else begin
        lsp = cruise;
        rsp = cruise;
      end
    end
    left_speed_q  = SPW'(lsp);
    right_speed_q = SPW'(rsp);
    motor_expected_q.push_back(motor_cmd(1'b0));
  endtask

  task automatic report(input string what, input motor_cmd_t exp, input motor_cmd_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] %s: exp fwd=%b/%b duty=%0d/%0d laps=%0d halt=%b", $time, what,
               exp.left_fwd, exp.right_fwd, exp.left_duty, exp.right_duty, exp.laps,
               exp.halted);
      $display("    got fwd=%b/%b duty=%0d/%0d laps=%0d halt=%b",
               got.left_fwd, got.right_fwd, got.left_duty, got.right_duty, got.laps,
               got.halted);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    motor_cmd_t got;
    motor_cmd_t exp;
    if (!rst_ni) begin
      reset_track();
      motor_expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) write_register(cfg_index_i, cfg_wdata_i);
      // pop before push: a result beat always belongs to an older sample beat
      if (out_valid_i && out_ready_i) begin
        got.left_fwd   = left_forward_i;
        got.right_fwd  = right_forward_i;
        got.left_duty  = left_duty_i;
        got.right_duty = right_duty_i;
        got.laps       = laps_done_i;
        got.halted     = stopped_for_good_i;
        if (motor_expected_q.size() == 0) begin
          report("result beat with nothing pending", '0, got);
        end else begin
          exp = motor_expected_q.pop_front();
          if (got !== exp) report("result mismatch", exp, got);
        end
      end
      if (in_valid_i && in_ready_i)
        steer_predict(left_sample_i, right_sample_i, obstacle_distance_i);
    end
    pending_count = motor_expected_q.size();
  end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the line-follow lap steering unit.
// ----------------------------------------------------------------------------
// Runs a short directed set (obstacle limits, both steering rules, reverse
// speed, reference extremes, one lap), then randomized register setups with
// lap runs, steering near the references and noise, under random gaps and
// result stalls. Ends with reaching the lap limit and beats while halted.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfls_pkg::*;

  localparam int SB           = SAMPLE_BITS_DEF;
  localparam int LB           = LAP_BITS_DEF;
  localparam int SMAX         = (1 << SB) - 1;
  localparam int LAP_MAX      = (1 << LB) - 1;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_BEATS  = 60;
  localparam int LAP_BUDGET   = 12;

  typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_e;

  typedef struct {
    int cruise;
    int clockwise;
    int left_ref;
    int right_ref;
    int lap_limit;
    int obstacle;
    int black;
    int white;
  } track_setup_t;

  logic                 clk_i               = 1'b0;
  logic                 rst_ni              = 1'b0;
  logic                 in_valid_i          = 1'b0;
  logic                 in_ready_o;
  logic [SB-1:0]        left_sample_i       = '0;
  logic [SB-1:0]        right_sample_i      = '0;
  logic [SB-1:0]        obstacle_distance_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i         = 1'b0;
  logic                 left_forward_o;
  logic                 right_forward_o;
  logic [DUTY_W-1:0]    left_duty_o;
  logic [DUTY_W-1:0]    right_duty_o;
  logic [LB-1:0]        laps_done_o;
  logic                 stopped_for_good_o;
  logic                 cfg_valid_i         = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i         = '0;
  logic [SB-1:0]        cfg_wdata_i         = '0;

  int pending;
  int mismatches;

  track_setup_t trk;
  idle_mode_e   in_mode    = IDLE_LIGHT;
  idle_mode_e   out_mode   = IDLE_LIGHT;
  int           stall_left = 0;
  int           cycles     = 0;
  int           beats_sent = 0;
  int           setups     = 0;
  int           laps_seen  = 0;
  bit           halt_seen  = 1'b0;

  line_follow_lap_steering_unit dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .left_sample_i,
    .right_sample_i,
    .obstacle_distance_i,
    .out_valid_o,
    .out_ready_i,
    .left_forward_o,
    .right_forward_o,
    .left_duty_o,
    .right_duty_o,
    .laps_done_o,
    .stopped_for_good_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_wdata_i
  );

  lfls_steering_checker u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i          (in_ready_o),
    .left_sample_i,
    .right_sample_i,
    .obstacle_distance_i,
    .out_valid_i         (out_valid_o),
    .out_ready_i,
    .left_forward_i      (left_forward_o),
    .right_forward_i     (right_forward_o),
    .left_duty_i         (left_duty_o),
    .right_duty_i        (right_duty_o),
    .laps_done_i         (laps_done_o),
    .stopped_for_good_i  (stopped_for_good_o),
    .cfg_valid_i,
    .cfg_ready_i         (cfg_ready_o),
    .cfg_index_i,
    .cfg_wdata_i,
    .pending_o           (pending),
    .errors_o            (mismatches)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (out_valid_o && out_ready_i) begin
      laps_seen <= int'(laps_done_o);
      if (stopped_for_good_o) halt_seen <= 1'b1;
    end
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int pick_gap(input idle_mode_e mode);
    int roll;
    roll = $urandom_range(0, 99);
    case (mode)
      IDLE_NONE:  return 0;
      IDLE_LIGHT: begin
        if (roll < 75) return 0;
        if (roll < 96) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
      end
      default: begin
        if (roll < 40) return 0;
        if (roll < 92) return $urandom_range(1, 4);
        return $urandom_range(15, 40);
      end
    endcase
  endfunction

  // result-side backpressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      stall_left = pick_gap(out_mode);
      out_ready_i <= (stall_left == 0);
      if (stall_left > 0) stall_left = stall_left - 1;
    end
  end

  function automatic int clip(input int v);
    return (v < 0) ? 0 : (v > SMAX) ? SMAX : v;
  endfunction

  function automatic int with_junk(input int value, input int width);
    return $urandom_range(0, 1) ? (value | int'($urandom << width)) : value;
  endfunction

  function automatic track_setup_t make_setup(input int cruise, input int cw,
                                              input int lref, input int rref,
                                              input int lap, input int obs,
                                              input int black, input int white);
    track_setup_t s;
    s.cruise    = cruise;
    s.clockwise = cw;
    s.left_ref  = lref;
    s.right_ref = rref;
    s.lap_limit = lap;
    s.obstacle  = obs;
    s.black     = black;
    s.white     = white;
    return s;
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= SB'(value);
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic apply_setup();
    write_reg(REG_CRUISE, with_junk(trk.cruise, CRUISE_W));
    write_reg(REG_CLOCKWISE, with_junk(trk.clockwise, 1));
    write_reg(REG_LEFT_REF, trk.left_ref);
    write_reg(REG_RIGHT_REF, trk.right_ref);
    write_reg(REG_LAP_LIMIT, with_junk(trk.lap_limit, LB));
    write_reg(REG_OBSTACLE, trk.obstacle);
    write_reg(REG_BLACK, trk.black);
    write_reg(REG_WHITE, trk.white);
    cfg_valid_i <= 1'b0;
    setups++;
  endtask

  task automatic send_beat(input int ls, input int rs, input int distance);
    int gap;
    gap = pick_gap(in_mode);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i          <= 1'b1;
    left_sample_i       <= SB'(ls);
    right_sample_i      <= SB'(rs);
    obstacle_distance_i <= SB'(distance);
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    @(negedge clk_i);
    beats_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic int clear_dist();
    return (trk.obstacle >= SMAX) ? SMAX : $urandom_range(trk.obstacle + 1, SMAX);
  endfunction

  function automatic int pick_dist();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return trk.obstacle;
    if (roll < 8) return clip(trk.obstacle + 1);
    if (roll < 16) return $urandom_range(0, trk.obstacle);
    return clear_dist();
  endfunction

  function automatic int black_val();
    return (trk.black < SMAX) ? $urandom_range(trk.black + 1, SMAX) : SMAX;
  endfunction

  function automatic int white_val();
    return (trk.white > 0) ? $urandom_range(0, trk.white - 1) : 0;
  endfunction

  function automatic int mid_val();
    return $urandom_range(trk.white, trk.black);
  endfunction

  task automatic steer_beat();
    send_beat(clip(trk.left_ref + int'($urandom_range(0, 80)) - 40),
              clip(trk.right_ref + int'($urandom_range(0, 80)) - 40), pick_dist());
  endtask

  task automatic noise_beat();
    send_beat($urandom_range(0, SMAX), $urandom_range(0, SMAX), $urandom_range(0, SMAX));
  endtask

  // both sensors over black, then both back on white unless the lap is left open
  task automatic lap_run(input bit complete);
    if ($urandom_range(0, 1)) begin
      send_beat(black_val(), black_val(), clear_dist());
    end else begin
      send_beat(black_val(), mid_val(), clear_dist());
      send_beat(mid_val(), black_val(), clear_dist());
    end
    if ($urandom_range(0, 4) == 0)
      send_beat(black_val(), white_val(), $urandom_range(0, trk.obstacle));
    if ($urandom_range(0, 2) == 0) send_beat(mid_val(), mid_val(), clear_dist());
    if (complete || $urandom_range(0, 4) != 0) begin
      if ($urandom_range(0, 1)) begin
        send_beat(white_val(), white_val(), clear_dist());
      end else begin
        send_beat(white_val(), mid_val(), clear_dist());
        send_beat(mid_val(), white_val(), clear_dist());
      end
    end
  endtask

  task automatic random_setup(input bit lap_phase);
    int roll;
    roll = $urandom_range(0, 99);
    trk.cruise = (roll < 10) ? 0 : (roll < 20) ? 255 :
                 (roll < 40) ? $urandom_range(1, 8) : $urandom_range(0, 255);
    trk.clockwise = $urandom_range(0, 1);
    trk.lap_limit = LAP_MAX;
    trk.obstacle  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 200);
    if (lap_phase) begin
      trk.left_ref  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 900);
      trk.right_ref = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 900);
      trk.black     = $urandom_range(950, SMAX - 1);
      trk.white     = $urandom_range(1, 100);
    end else begin
      roll = $urandom_range(0, 9);
      trk.left_ref  = (roll == 0) ? 0 : (roll == 1) ? SMAX : $urandom_range(0, SMAX);
      roll = $urandom_range(0, 9);
      trk.right_ref = (roll == 0) ? 0 : (roll == 1) ? SMAX : $urandom_range(0, SMAX);
      trk.black     = SMAX;
      trk.white     = $urandom_range(0, SMAX);
    end
    apply_setup();
  endtask

  task automatic run_phase(input bit lap_phase, input int beats);
    int roll;
    int planned;
    planned  = 0;
    in_mode  = idle_mode_e'($urandom_range(0, 2));
    out_mode = idle_mode_e'($urandom_range(0, 2));
    repeat (beats) begin
      roll = $urandom_range(0, 99);
      if (lap_phase && roll < 15 && laps_seen + planned < LAP_BUDGET) begin
        lap_run(1'b0);
        planned++;
      end else if (roll < 80) begin
        steer_beat();
      end else begin
        noise_beat();
      end
    end
    drain();
  endtask

  task automatic directed_run();
    // reset settings: obstacle limits, clockwise right trim, one lap
    send_beat(0, 0, 0);
    send_beat(0, 0, 30);
    send_beat(0, 0, 31);
    send_beat(SMAX, SMAX, SMAX);
    send_beat(SMAX, SMAX, SMAX);
    send_beat(0, 0, SMAX);
    drain();
    // anticlockwise with low cruise: left speed goes to reverse, then to zero
    trk = make_setup(3, 0, 0, 0, LAP_MAX, 0, SMAX, 0);
    apply_setup();
    send_beat(0, 512, 1);
    send_beat(6, 512, 1);
    send_beat(SMAX, 512, 1);
    send_beat(5, 6, 0);
    send_beat(5, 6, 1);
    drain();
    // full cruise, references at the top end
    trk = make_setup(255, 1, SMAX, 1001, LAP_MAX, 500, SMAX, 0);
    apply_setup();
    send_beat(1001, 0, 501);
    send_beat(1002, SMAX, SMAX);
    send_beat(1002, 1022, 500);
    send_beat(1002, 1022, 600);
    drain();
    // every distance is an obstacle
    trk = make_setup(100, 0, SMAX, SMAX, LAP_MAX, SMAX, 0, SMAX);
    apply_setup();
    send_beat(SMAX, SMAX, SMAX);
    send_beat(0, 0, 0);
    drain();
    trk = make_setup(100, 0, SMAX, SMAX, LAP_MAX, 0, SMAX, 0);
    apply_setup();
    send_beat(0, 1017, SMAX);
    send_beat(SMAX, 1018, SMAX);
    drain();
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    directed_run();

    for (int p = 0; p < RAND_PHASES; p++) begin
      random_setup((p % 2 == 0) && laps_seen < 10);
      run_phase((p % 2 == 0) && laps_seen < 10, PHASE_BEATS);
    end

    // last lap steers, the next clear beat halts for good
    trk = make_setup($urandom_range(0, 255), $urandom_range(0, 1), 500, 500,
                     (laps_seen < LAP_MAX) ? laps_seen + 1 : LAP_MAX, 20, 1000, 50);
    apply_setup();
    lap_run(1'b1);
    steer_beat();
    steer_beat();
    repeat (30) begin
      if ($urandom_range(0, 1)) steer_beat();
      else noise_beat();
    end
    drain();

    trk = make_setup(255, 0, 0, SMAX, 0, SMAX, 0, SMAX);
    apply_setup();
    repeat (10) noise_beat();
    drain();

    repeat (8) @(negedge clk_i);
    $display("Sent %0d sample beats over %0d register setups in both steering modes,",
             beats_sent, setups);
    $display("with obstacle stops, reverse speeds and %0d laps; halt %s.", laps_seen,
             halt_seen ? "reached" : "not reached");
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/lfls_pkg.sv
rtl/lfls_cfg.sv
rtl/lfls_core.sv
rtl/line_follow_lap_steering_unit.sv
test/lfls_steering_checker.sv
test/tb.sv
